@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define FBPA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define FBPA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/fbpa_pkg.sv @@
// shared constants, codes and control types of the block pool allocator
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int ADDR_W     = 32;
    localparam int BB_W       = 17;
    localparam int CNT_W      = 7;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int SPAN_W     = BB_W + IDX_W;
    localparam int DIVK_W     = (IDX_W > 1) ? $clog2(IDX_W) : 1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT       = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [BB_W-1:0]  RST_BLOCK_BYTES = BB_W'(4096);
    localparam logic [CNT_W-1:0] RST_LIMIT       = CNT_W'(64);
    localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] MAX_BLOCKS_CNT  = CNT_W'(MAX_BLOCKS);
    localparam logic [DIVK_W-1:0] DIVK_TOP       = DIVK_W'(IDX_W - 1);

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit_alloc;
        logic report_full;
        logic span_calc;
        logic div_init;
        logic report_range;
        logic div_step;
        logic commit_free;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_end;
        logic scan_free;
        logic in_range;
        logic div_last;
    } t_dp_stat;

endpackage

@@ rtl/core/fbpa_ctrl.sv @@
// sequencer for allocate and free requests
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_mode,
    input  fbpa_pkg::t_dp_stat i_stat,
    output fbpa_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_strobe
);
    import fbpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SPAN,
        S_RANGE,
        S_DIV,
        S_FREE
    } t_state;

    t_state  r_state, n_state;
    logic    r_busy, n_busy;
    logic    r_strobe, n_strobe;
    t_dp_cmd cmd;
    logic    finish;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        finish  = 1'b0;
        n_busy  = r_busy;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_busy   = 1'b1;
                    n_state  = (i_mode == MODE_FREE) ? S_SPAN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    cmd.report_full = 1'b1;
                    finish          = 1'b1;
                end else if (i_stat.scan_free) begin
                    cmd.commit_alloc = 1'b1;
                    finish           = 1'b1;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_SPAN: begin
                cmd.span_calc = 1'b1;
                n_state       = S_RANGE;
            end
            S_RANGE: begin
                if (i_stat.in_range) begin
                    cmd.div_init = 1'b1;
                    n_state      = S_DIV;
                end else begin
                    cmd.report_range = 1'b1;
                    finish           = 1'b1;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FREE;
                end
            end
            S_FREE: begin
                cmd.commit_free = 1'b1;
                finish          = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
        if (finish) begin
            n_state = S_IDLE;
            n_busy  = 1'b0;
        end
        n_strobe = finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= n_busy;
            r_strobe <= n_strobe;
        end
    end

    assign o_cmd    = cmd;
    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

    `FBPA_ASSERT(a_accept_busy, i_start && !o_busy |=> o_busy, "accepted request did not go busy")
    `FBPA_ASSERT(a_cmd_single, $onehot0(o_cmd), "more than one datapath command at once")
    `FBPA_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_busy && !o_strobe, "busy or strobe after reset")

endmodule

@@ rtl/core/fbpa_dp.sv @@
// used map, in-use counter, config registers, scan and divide datapath
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbpa_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic [fbpa_pkg::ADDR_W-1:0]    i_block_address,
    input  fbpa_pkg::t_dp_cmd              i_cmd,
    output fbpa_pkg::t_dp_stat             o_stat,
    output logic [fbpa_pkg::STAT_W-1:0]    o_status,
    output logic [fbpa_pkg::ADDR_W-1:0]    o_granted_address,
    output logic [fbpa_pkg::CNT_W-1:0]     o_used_count
);
    import fbpa_pkg::*;

    // configuration
    logic [ADDR_W-1:0] r_base;
    logic [BB_W-1:0]   r_bb;
    logic [CNT_W-1:0]  r_limit;

    // pool state
    logic [MAX_BLOCKS-1:0] r_used;
    logic [CNT_W-1:0]      r_in_use;

    // per-request working registers
    logic [BB_W-1:0]   r_size;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W:0]   r_diff;
    logic [CNT_W-1:0]  r_idx;
    logic [SPAN_W-1:0] r_acc;
    logic [SPAN_W-1:0] r_span;
    logic [SPAN_W-1:0] r_rem;
    logic [IDX_W-1:0]  r_quo;
    logic [DIVK_W-1:0] r_k;

    // result registers
    logic [STAT_W-1:0] r_status;
    logic [ADDR_W-1:0] r_granted;
    logic [CNT_W-1:0]  r_used_cnt;

    logic [BB_W-1:0]   eff_size;
    logic [CNT_W-1:0]  eff_cnt;
    logic [SPAN_W-1:0] trial;
    logic              trial_ge;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  cnt_dec;

    assign eff_size = (r_bb == '0) ? BB_W'(1) : r_bb;
    assign eff_cnt  = (r_limit > MAX_BLOCKS_CNT) ? MAX_BLOCKS_CNT : r_limit;

    // restoring divide, one quotient bit per step from the top
    assign trial    = SPAN_W'(r_size) << r_k;
    assign trial_ge = (r_rem >= trial);

    assign cnt_inc = (r_in_use != CNT_MAX) ? r_in_use + CNT_W'(1) : r_in_use;
    assign cnt_dec = (r_in_use != '0) ? r_in_use - CNT_W'(1) : r_in_use;

    assign o_stat.scan_end  = (r_idx >= r_cnt);
    assign o_stat.scan_free = !r_used[r_idx[IDX_W-1:0]];
    assign o_stat.in_range  = !r_diff[ADDR_W]
                              && (r_diff[ADDR_W-1:0] < ADDR_W'(r_span));
    assign o_stat.div_last  = (r_k == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_bb     <= RST_BLOCK_BYTES;
            r_limit  <= RST_LIMIT;
            r_used   <= '0;
            r_in_use <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_POOL_BASE:   r_base  <= i_cfg_data;
                    CFG_BLOCK_BYTES: r_bb    <= i_cfg_data[BB_W-1:0];
                    CFG_LIMIT:       r_limit <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit_alloc) begin
                r_used[r_idx[IDX_W-1:0]] <= 1'b1;
                r_in_use                 <= cnt_inc;
            end
            if (i_cmd.commit_free) begin
                r_used[r_quo] <= 1'b0;
                r_in_use      <= cnt_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_size <= eff_size;
            r_cnt  <= eff_cnt;
            r_diff <= {1'b0, i_block_address} - {1'b0, r_base};
            r_idx  <= '0;
            r_acc  <= '0;
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + CNT_W'(1);
            r_acc <= r_acc + SPAN_W'(r_size);
        end
        if (i_cmd.span_calc) begin
            r_span <= SPAN_W'(r_cnt) * SPAN_W'(r_size);
        end
        if (i_cmd.div_init) begin
            r_rem <= r_diff[SPAN_W-1:0];
            r_quo <= '0;
            r_k   <= DIVK_TOP;
        end
        if (i_cmd.div_step) begin
            if (trial_ge) begin
                r_rem <= r_rem - trial;
            end
            r_quo <= {r_quo[IDX_W-2:0], trial_ge};
            r_k   <= r_k - DIVK_W'(1);
        end
        if (i_cmd.commit_alloc) begin
            r_status   <= ST_DONE;
            r_granted  <= r_base + ADDR_W'(r_acc);
            r_used_cnt <= cnt_inc;
        end
        if (i_cmd.commit_free) begin
            r_status   <= ST_DONE;
            r_granted  <= '0;
            r_used_cnt <= cnt_dec;
        end
        if (i_cmd.report_full) begin
            r_status   <= ST_FULL;
            r_granted  <= '0;
            r_used_cnt <= r_in_use;
        end
        if (i_cmd.report_range) begin
            r_status   <= ST_RANGE;
            r_granted  <= '0;
            r_used_cnt <= r_in_use;
        end
    end

    assign o_status          = r_status;
    assign o_granted_address = r_granted;
    assign o_used_count      = r_used_cnt;

    `FBPA_ASSERT(a_count_vs_map, $countones(r_used) >= r_in_use, "in-use count above marked blocks")
    `FBPA_ASSERT(a_alloc_free_slot, i_cmd.commit_alloc |-> !r_used[r_idx[IDX_W-1:0]] && (r_idx < r_cnt), "allocating a taken or out-of-pool block")
    `FBPA_ASSERT(a_free_index, i_cmd.commit_free |-> (CNT_W'(r_quo) < r_cnt), "freed index beyond block count")

endmodule

@@ rtl/core/fixed_block_pool_allocator_core.sv @@
// top level of the fixed-size block pool allocator
`timescale 1ns / 1ps

// Bitmap allocator over a pool of equal-size blocks. Pulse i_start while
// o_busy is low with i_mode 0 to allocate the lowest free block or 1 to give
// back the block holding i_block_address. Each request yields exactly one
// result, shown for a single cycle with o_strobe; there is no backpressure,
// so capture it on that cycle. An allocate walks the used map one block per
// cycle and reports at the first free block or, once it passes the effective
// block count, reports a full pool. A free computes the pool span with one
// multiply, range-checks, then runs a six-step restoring divide by the block
// size; an out-of-range address is reported without running the divide.
// A new request may be issued on the strobe cycle. Configuration
// registers (0 pool base, 1 block bytes, 2 block count) are always ready and
// should be written only while idle. The used map and count clear at reset.
module fixed_block_pool_allocator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_mode,
    input  logic [fbpa_pkg::ADDR_W-1:0]    i_block_address,
    output logic                           o_strobe,
    output logic [fbpa_pkg::STAT_W-1:0]    o_status,
    output logic [fbpa_pkg::ADDR_W-1:0]    o_granted_address,
    output logic [fbpa_pkg::CNT_W-1:0]     o_used_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    i_cfg_data
);
    import fbpa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    fbpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_mode   (i_mode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_strobe (o_strobe)
    );

    fbpa_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_block_address   (i_block_address),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_used_count      (o_used_count)
    );

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the fixed-size block pool allocator core
`timescale 1ns / 1ps

module tb_top;

    import fbpa_pkg::*;

    localparam int                   RANDOM_PHASES   = 12;
    localparam int                   ITEMS_PER_PHASE = 125;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE       = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] granted_address;
        logic [CNT_W-1:0]  used_count;
    } t_pool_reply;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_start         = 1'b0;
    logic                 i_mode          = 1'b0;
    logic [ADDR_W-1:0]    i_block_address = '0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [ADDR_W-1:0]    i_cfg_data      = '0;
    logic                 o_busy;
    logic                 o_strobe;
    logic [STAT_W-1:0]    o_status;
    logic [ADDR_W-1:0]    o_granted_address;
    logic [CNT_W-1:0]     o_used_count;
    logic                 o_cfg_ready;

    // mirror of the pool state and its settings
    logic [ADDR_W-1:0]     pool_base_q   = '0;
    logic [BB_W-1:0]       block_bytes_q = RST_BLOCK_BYTES;
    logic [CNT_W-1:0]      limit_q       = RST_LIMIT;
    logic [MAX_BLOCKS-1:0] taken_map     = '0;
    logic [CNT_W-1:0]      in_use_q      = '0;

    t_pool_reply awaited_replies[$];
    int          errors       = 0;
    int          n_requests   = 0;
    int          n_settings   = 0;
    int          n_grants     = 0;
    int          n_full       = 0;
    int          n_range      = 0;
    bit          gaps_on      = 1'b1;

    fixed_block_pool_allocator_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_mode            (i_mode),
        .i_block_address   (i_block_address),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_granted_address (o_granted_address),
        .o_used_count      (o_used_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] eff_size();
        return (block_bytes_q == '0) ? 64'd1 : 64'(block_bytes_q);
    endfunction

    function automatic logic [63:0] eff_count();
        return (limit_q > MAX_BLOCKS_CNT) ? 64'(MAX_BLOCKS) : 64'(limit_q);
    endfunction

    // applies one request to the mirror and returns the reply it must produce
    function automatic t_pool_reply pool_reply(input logic mode, input logic [ADDR_W-1:0] addr);
        t_pool_reply reply;
        logic [63:0] size, count, offset, idx;
        int          hit;
        int          k;
        reply  = '0;
        size   = eff_size();
        count  = eff_count();
        hit    = -1;
        if (mode == MODE_ALLOC) begin
            for (k = 0; k < int'(count); k++) begin
                if (!taken_map[k] && hit < 0) hit = k;
            end
            if (hit >= 0) begin
                taken_map[hit]        = 1'b1;
                if (in_use_q != CNT_MAX) in_use_q = in_use_q + CNT_W'(1);
                reply.granted_address = ADDR_W'(64'(pool_base_q) + 64'(hit) * size);
                reply.status          = ST_DONE;
            end else begin
                reply.status = ST_FULL;
            end
        end else begin
            offset = 64'(addr) - 64'(pool_base_q);
            // no wrap: anything below the base is outside
            if (addr >= pool_base_q && offset < count * size) begin
                idx = offset / size;
                if (idx < 64'(MAX_BLOCKS)) taken_map[idx[IDX_W-1:0]] = 1'b0;
                if (in_use_q != '0) in_use_q = in_use_q - CNT_W'(1);
                reply.status = ST_DONE;
            end else begin
                reply.status = ST_RANGE;
            end
        end
        reply.used_count = in_use_q;
        return reply;
    endfunction

    task automatic idle_burst(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_start         <= 1'b0;
            i_mode          <= 1'($urandom);
            i_block_address <= $urandom;
        end
    endtask

    // start stays high when requests come back to back
    task automatic send_request(input logic mode, input logic [ADDR_W-1:0] addr);
        if (gaps_on && $urandom_range(3) == 0) idle_burst($urandom_range(1, 3));
        @(negedge i_clk);
        i_start         <= 1'b1;
        i_mode          <= mode;
        i_block_address <= addr;
        do @(posedge i_clk); while (o_busy);
        awaited_replies.push_back(pool_reply(mode, addr));
        n_requests++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_POOL_BASE:   pool_base_q   = data;
            CFG_BLOCK_BYTES: block_bytes_q = data[BB_W-1:0];
            CFG_LIMIT:       limit_q       = data[CNT_W-1:0];
            default:         ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= $urandom;
    endtask

    task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [BB_W-1:0] bytes,
                            input logic [CNT_W-1:0] limit, input bit junk);
        cfg_write(CFG_POOL_BASE, base);
        cfg_write(CFG_BLOCK_BYTES, {junk ? 15'($urandom) : 15'd0, bytes});
        cfg_write(CFG_LIMIT, {junk ? 25'($urandom) : 25'd0, limit});
        n_settings++;
    endtask

    always @(posedge i_clk) begin : check_replies
        t_pool_reply exp_r;
        if (i_rst_n && o_strobe) begin
            if (awaited_replies.size() == 0) begin
                $display("%0t: reply with no request pending: status %0d addr %h count %0d",
                         $time, o_status, o_granted_address, o_used_count);
                errors++;
            end else begin
                exp_r = awaited_replies.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_r.status, o_status);
                    errors++;
                end
                if (o_granted_address !== exp_r.granted_address) begin
                    $display("%0t: granted_address expected %h actual %h",
                             $time, exp_r.granted_address, o_granted_address);
                    errors++;
                end
                if (o_used_count !== exp_r.used_count) begin
                    $display("%0t: used_count expected %0d actual %0d",
                             $time, exp_r.used_count, o_used_count);
                    errors++;
                end
                case (exp_r.status)
                    ST_FULL:  n_full++;
                    ST_RANGE: n_range++;
                    default:  n_grants++;
                endcase
            end
        end
    end

    // reset settings: grants, a free inside a block, a double free, a free of an unused block, misses
    task automatic test_default_pool();
        send_request(MODE_ALLOC, 32'hFFFF_FFFF);
        send_request(MODE_ALLOC, 32'h0000_0000);
        send_request(MODE_FREE, 32'h0000_1005);
        send_request(MODE_FREE, 32'h0000_1000);
        send_request(MODE_FREE, 32'h0004_0000);
        send_request(MODE_FREE, 32'hFFFF_FFFF);
        send_request(MODE_FREE, 32'h0003_FFFF);
        send_request(MODE_ALLOC, 32'h5A5A_A5A5);
    endtask

    // pool running past the top of the address space
    task automatic test_pool_at_top();
        wait_idle();
        set_pool(32'hFFFF_0000, 17'h1_0000, 7'd2, 1'b0);
        cfg_write(CFG_SPARE, $urandom);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 32'h0000_0000);
        send_request(MODE_FREE, 32'hFFFF_FFFF);
        send_request(MODE_ALLOC, '0);
    endtask

    // empty pool, zero block size, oversized count, shrunk pool
    task automatic test_degenerate_sizes();
        wait_idle();
        cfg_write(CFG_LIMIT, 32'd0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 32'hFFFF_0000);
        wait_idle();
        set_pool(32'h0, 17'd0, 7'd127, 1'b1);
        send_request(MODE_ALLOC, '1);
        send_request(MODE_FREE, 32'h0000_0000);
        send_request(MODE_FREE, 32'h0000_0040);
        send_request(MODE_FREE, 32'h0000_003F);
        wait_idle();
        cfg_write(CFG_LIMIT, 32'd1);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 32'h0000_0005);
    endtask

    // mostly alloc/free of live blocks, some stray and edge addresses
    task automatic test_random_traffic();
        int              phase_i, item_i, pick, roll, alloc_pct, mix;
        logic [ADDR_W-1:0] base_v, addr;
        logic [BB_W-1:0]   bytes_v;
        logic [CNT_W-1:0]  limit_v;
        logic [63:0]       sz, cnt, offs;
        int                live[$];
        for (phase_i = 0; phase_i < RANDOM_PHASES; phase_i++) begin
            wait_idle();
            case (phase_i)
                0: begin base_v = '0; bytes_v = 17'd1; limit_v = 7'd64; end
                1: begin base_v = '1; bytes_v = 17'h1_0000; limit_v = 7'd1; end
                2: begin base_v = $urandom; bytes_v = 17'd0; limit_v = 7'd0; end
                3: begin base_v = 32'hFFF0_0000; bytes_v = 17'h1_FFFF; limit_v = 7'd127; end
                4: begin base_v = 32'h8000_0000; bytes_v = 17'($urandom_range(1, 64));
                         limit_v = 7'd100; end
                default: begin
                    mix = $urandom_range(3);
                    base_v = (mix == 0) ? 32'h0 : (mix == 1) ? 32'hFFFF_FFFF : $urandom;
                    mix = $urandom_range(9);
                    bytes_v = (mix == 0) ? 17'd0 : (mix == 1) ? 17'h1_0000 :
                              (mix == 2) ? 17'h1_FFFF :
                              (mix < 6) ? 17'($urandom_range(1, 64)) :
                              17'($urandom_range(1, 65536));
                    mix = $urandom_range(9);
                    limit_v = (mix == 0) ? 7'd0 : (mix == 1) ? 7'd1 : (mix == 2) ? 7'd64 :
                              (mix == 3) ? 7'($urandom_range(65, 127)) :
                              7'($urandom_range(1, 64));
                end
            endcase
            set_pool(base_v, bytes_v, limit_v, bit'($urandom_range(1)));
            if (phase_i >= RANDOM_PHASES - 2) gaps_on = 1'b0;
            alloc_pct = $urandom_range(35, 65);
            for (item_i = 0; item_i < ITEMS_PER_PHASE; item_i++) begin
                sz   = eff_size();
                cnt  = eff_count();
                roll = $urandom_range(99);
                if (roll < alloc_pct) begin
                    send_request(MODE_ALLOC, $urandom);
                end else if (roll < 92) begin
                    live.delete();
                    for (pick = 0; pick < int'(cnt); pick++)
                        if (taken_map[pick]) live.push_back(pick);
                    if (live.size() != 0) pick = live[$urandom_range(live.size() - 1)];
                    else pick = (cnt != 0) ? $urandom_range(int'(cnt) - 1) : 0;
                    offs = $urandom_range(1) ? 64'd0 : 64'($urandom_range(int'(sz) - 1));
                    addr = ADDR_W'(64'(pool_base_q) + 64'(pick) * sz + offs);
                    send_request(MODE_FREE, addr);
                end else begin
                    case ($urandom_range(3))
                        0: addr = $urandom;
                        1: addr = pool_base_q - ADDR_W'(1);
                        2: addr = ADDR_W'(64'(pool_base_q) + cnt * sz);
                        default: addr = ADDR_W'(64'(pool_base_q) + cnt * sz - 64'd1);
                    endcase
                    send_request(MODE_FREE, addr);
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_pool();
        test_pool_at_top();
        test_degenerate_sizes();
        test_random_traffic();
        wait_idle();
        repeat (80) @(posedge i_clk);
        $display("ran %0d requests across %0d pool settings", n_requests, n_settings);
        $display("replies: %0d done, %0d pool full, %0d out of range",
                 n_grants, n_full, n_range);
        if (errors == 0) begin
            $display("fixed_block_pool_allocator_core regression: pass");
        end else begin
            $display("fixed_block_pool_allocator_core regression: fail");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d replies outstanding", awaited_replies.size());
        $display("fixed_block_pool_allocator_core regression: fail");
        $finish;
    end

endmodule
